/* sv/tsr_pkg.sv */
`timescale 1ns / 1ps
package tsr_pkg;

  localparam int CoordBits  = 8;
  localparam int ColorBits  = 16;
  localparam int AccBits    = 2 * CoordBits + 2;
  localparam int QueueDepth = 2;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_ADVANCE = 1'b1
  } op_e;

  typedef struct packed {
    logic                 op;
    logic [CoordBits-1:0] vx0;
    logic [CoordBits-1:0] vy0;
    logic [CoordBits-1:0] vx1;
    logic [CoordBits-1:0] vy1;
    logic [CoordBits-1:0] vx2;
    logic [CoordBits-1:0] vy2;
    logic [ColorBits-1:0] fill_color;
  } in_t;

  typedef struct packed {
    logic [CoordBits-1:0] span_row;
    logic [CoordBits-1:0] span_left;
    logic [CoordBits-1:0] span_right;
    logic [ColorBits-1:0] span_color;
    logic                 span_last;
  } out_t;

  typedef struct packed {
    logic valid;
    logic full;
  } queue_status_t;

endpackage

/* sv/triangle_span_rasterizer_unit.sv */
`timescale 1ns / 1ps
// Load items are consumed by the back end once at the queue head; no result.
// A scan span pops its item and starts the first of two 18-step signed divisions
// through the shared serial divider, then registers the span and issues it.
// A span of a triangle on one row uses no division. Input queue holds QDEPTH items.
// Reset (rst_ni low, asynchronous) empties the queue, idles the scan and clears state.
module triangle_span_rasterizer_unit #(
  parameter int QDEPTH = tsr_pkg::QueueDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tsr_pkg::in_t  in_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output tsr_pkg::out_t out_o,
  output logic          out_valid_o,
  input  logic          out_stall_i
);

  tsr_pkg::in_t                           head;
  tsr_pkg::queue_status_t                 qstat;
  logic                                   pop;
  logic                                   div_start, div_busy, div_done;
  logic signed [tsr_pkg::AccBits-1:0]     div_num, div_quo;
  logic        [tsr_pkg::CoordBits-1:0]   div_den;

  tsr_front #(.QDEPTH(QDEPTH)) u_front (
    .clk_i, .rst_ni, .in_i, .in_valid_i, .in_stall_o,
    .pop_i(pop), .head_o(head), .status_o(qstat)
  );

  tsr_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .busy_o(div_busy), .done_o(div_done), .quo_o(div_quo)
  );

  tsr_back u_back (
    .clk_i, .rst_ni, .head_i(head), .head_valid_i(qstat.valid), .pop_o(pop),
    .div_start_o(div_start), .div_num_o(div_num), .div_den_o(div_den),
    .div_done_i(div_done), .div_quo_i(div_quo),
    .out_o, .out_valid_o, .out_stall_i
  );

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> qstat.valid) else $error("pop from empty queue");

  a_div_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_start && div_busy) |-> div_done) else $error("divider restarted while busy");

  a_pop_no_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> !$rose(out_valid_o)) else $error("span issued too early after pop");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> qstat.full) else $error("stall without full queue");

endmodule

/* sv/tsr_front.sv */
`timescale 1ns / 1ps
module tsr_front #(
  parameter int QDEPTH = tsr_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tsr_pkg::in_t          in_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  pop_i,
  output tsr_pkg::in_t          head_o,
  output tsr_pkg::queue_status_t status_o
);

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CW = $clog2(QDEPTH + 1);

  tsr_pkg::in_t   mem_q [QDEPTH];
  logic [PW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           push, pop;

  assign status_o.valid = (cnt_q != '0);
  assign status_o.full  = (cnt_q == CW'(QDEPTH));
  assign in_stall_o     = status_o.full;
  assign push           = in_valid_i && !status_o.full;
  assign pop            = pop_i && status_o.valid;
  assign head_o         = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(QDEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop) begin
      rd_d = (rd_q == PW'(QDEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_i;
    end
  end

endmodule

/* sv/tsr_div.sv */
`timescale 1ns / 1ps
module tsr_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic signed [tsr_pkg::AccBits-1:0]    num_i,
  input  logic        [tsr_pkg::CoordBits-1:0]  den_i,
  output logic                                  busy_o,
  output logic                                  done_o,
  output logic signed [tsr_pkg::AccBits-1:0]    quo_o
);

  localparam int W  = tsr_pkg::AccBits;
  localparam int DB = tsr_pkg::CoordBits;
  localparam int CW = $clog2(W);

  logic          busy_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  mag_q;
  logic [DB-1:0] rem_q;
  logic [DB-1:0] den_q;
  logic          neg_q, dz_q;
  logic [DB:0]   rem_sh;
  logic [DB-1:0] rem_nx;
  logic          ge;
  logic [W-1:0]  q_mag;

  assign rem_sh = {rem_q, mag_q[W-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});
  assign rem_nx = ge ? DB'(rem_sh - {1'b0, den_q}) : rem_sh[DB-1:0];
  assign q_mag  = {mag_q[W-2:0], ge};
  assign busy_o = busy_q;
  assign done_o = busy_q && (cnt_q == CW'(W - 1));
  assign quo_o  = dz_q ? '0 : (neg_q ? -$signed(q_mag) : $signed(q_mag));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= num_i[W-1] ? -num_i : num_i;
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[W-1];
      dz_q  <= (den_i == '0);
    end else if (busy_q) begin
      mag_q <= q_mag;
      rem_q <= rem_nx;
    end
  end

endmodule

/* sv/tsr_back.sv */
`timescale 1ns / 1ps
module tsr_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tsr_pkg::in_t                          head_i,
  input  logic                                  head_valid_i,
  output logic                                  pop_o,
  output logic                                  div_start_o,
  output logic signed [tsr_pkg::AccBits-1:0]    div_num_o,
  output logic        [tsr_pkg::CoordBits-1:0]  div_den_o,
  input  logic                                  div_done_i,
  input  logic signed [tsr_pkg::AccBits-1:0]    div_quo_i,
  output tsr_pkg::out_t                         out_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i
);

  localparam int CB = tsr_pkg::CoordBits;
  localparam int AW = tsr_pkg::AccBits;

  typedef enum logic [1:0] {PH_IDLE, PH_FLAT, PH_SCAN} phase_e;
  typedef enum logic [1:0] {S_WAIT, S_DIVL, S_DIVR, S_EMIT} state_e;

  state_e                   st_q;
  phase_e                   phase_q;
  logic [CB-1:0]            sx_q [3];
  logic [CB-1:0]            sy_q [3];
  logic [CB:0]              row_q;
  logic signed [AW-1:0]     lacc_q, racc_q;
  logic [tsr_pkg::ColorBits-1:0] color_q;
  logic                     upper_q, scan_q;
  logic signed [AW-1:0]     a_q;
  tsr_pkg::out_t            span_q, out_q;
  logic                     out_valid_q;

  logic [CB-1:0] ax [3];
  logic [CB-1:0] ay [3];
  logic [CB-1:0] bx [3];
  logic [CB-1:0] by [3];
  logic [CB-1:0] cx [3];
  logic [CB-1:0] cy [3];
  logic [CB-1:0] lo, hi;
  logic          upper, out_free;
  logic signed [AW-1:0] lnum, b_val;
  logic signed [AW-1:0] dx01, dx12, dx02;

  always_comb begin
    ax[0] = head_i.vx0; ay[0] = head_i.vy0;
    ax[1] = head_i.vx1; ay[1] = head_i.vy1;
    ax[2] = head_i.vx2; ay[2] = head_i.vy2;
    bx = ax; by = ay;
    if (ay[0] > ay[1]) begin
      bx[0] = ax[1]; by[0] = ay[1]; bx[1] = ax[0]; by[1] = ay[0];
    end
    cx = bx; cy = by;
    if (by[1] > by[2]) begin
      cx[1] = bx[2]; cy[1] = by[2]; cx[2] = bx[1]; cy[2] = by[1];
    end
    bx = cx; by = cy;
    if (cy[0] > cy[1]) begin
      bx[0] = cx[1]; by[0] = cy[1]; bx[1] = cx[0]; by[1] = cy[0];
    end
  end

  always_comb begin
    lo = sx_q[0];
    hi = sx_q[0];
    for (int i = 1; i < 3; i++) begin
      if (sx_q[i] < lo) lo = sx_q[i];
      if (sx_q[i] > hi) hi = sx_q[i];
    end
  end

  assign upper = (row_q < {1'b0, sy_q[1]}) ||
                 ((row_q == {1'b0, sy_q[1]}) && (sy_q[1] == sy_q[2]));
  assign lnum  = (!upper && (row_q == {1'b0, sy_q[1]})) ? '0 : lacc_q;
  assign dx01  = AW'($signed({1'b0, sx_q[1]}) - $signed({1'b0, sx_q[0]}));
  assign dx12  = AW'($signed({1'b0, sx_q[2]}) - $signed({1'b0, sx_q[1]}));
  assign dx02  = AW'($signed({1'b0, sx_q[2]}) - $signed({1'b0, sx_q[0]}));
  assign b_val = $signed({{(AW-CB){1'b0}}, sx_q[0]}) + div_quo_i;

  assign pop_o       = (st_q == S_WAIT) && head_valid_i;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_o       = out_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    div_start_o = 1'b0;
    div_num_o   = racc_q;
    div_den_o   = sy_q[2] - sy_q[0];
    if (st_q == S_WAIT) begin
      div_start_o = pop_o && (head_i.op == tsr_pkg::OP_ADVANCE) && (phase_q == PH_SCAN);
      div_num_o   = lnum;
      div_den_o   = upper ? (sy_q[1] - sy_q[0]) : (sy_q[2] - sy_q[1]);
    end else if (st_q == S_DIVL) begin
      div_start_o = div_done_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_WAIT;
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        sx_q[i] <= '0;
        sy_q[i] <= '0;
      end
      row_q   <= '0;
      lacc_q  <= '0;
      racc_q  <= '0;
      color_q <= '0;
      upper_q <= 1'b0;
      scan_q  <= 1'b0;
      a_q     <= '0;
      span_q  <= '0;
      out_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (st_q)
        S_WAIT: begin
          if (pop_o) begin
            if (head_i.op == tsr_pkg::OP_LOAD) begin
              sx_q    <= bx;
              sy_q    <= by;
              color_q <= head_i.fill_color;
              row_q   <= {1'b0, by[0]};
              lacc_q  <= '0;
              racc_q  <= '0;
              phase_q <= (by[0] == by[2]) ? PH_FLAT : PH_SCAN;
            end else if (phase_q == PH_FLAT) begin
              span_q <= '{span_row: sy_q[0], span_left: lo, span_right: hi,
                          span_color: color_q, span_last: 1'b1};
              scan_q <= 1'b0;
              st_q   <= S_EMIT;
            end else if (phase_q == PH_SCAN) begin
              lacc_q  <= lnum;
              upper_q <= upper;
              scan_q  <= 1'b1;
              st_q    <= S_DIVL;
            end
          end
        end
        S_DIVL: begin
          if (div_done_i) begin
            a_q  <= $signed({{(AW-CB){1'b0}}, upper_q ? sx_q[0] : sx_q[1]}) + div_quo_i;
            st_q <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_done_i) begin
            span_q.span_row   <= row_q[CB-1:0];
            span_q.span_left  <= (a_q > b_val) ? b_val[CB-1:0] : a_q[CB-1:0];
            span_q.span_right <= (a_q > b_val) ? a_q[CB-1:0] : b_val[CB-1:0];
            span_q.span_color <= color_q;
            span_q.span_last  <= (row_q >= {1'b0, sy_q[2]});
            st_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_q       <= span_q;
            out_valid_q <= 1'b1;
            st_q        <= S_WAIT;
            if (span_q.span_last) begin
              phase_q <= PH_IDLE;
            end else if (scan_q) begin
              lacc_q <= lacc_q + (upper_q ? dx01 : dx12);
              racc_q <= racc_q + dx02;
              row_q  <= row_q + (CB+1)'(1);
            end
          end
        end
        default: st_q <= S_WAIT;
      endcase
    end
  end

endmodule

/* bench/triangle_span_rasterizer_unit_test.sv */
`timescale 1ns / 1ps
module triangle_span_rasterizer_unit_test;
  import tsr_pkg::*;

  localparam int IdleLimit = 20000;

  class span_scoreboard;
    logic [CoordBits-1:0] vx[3];
    logic [CoordBits-1:0] vy[3];
    logic [CoordBits:0] row_q;
    logic [CoordBits-1:0] mid_row;
    int left_acc;
    int right_acc;
    int scan_phase;
    logic [ColorBits-1:0] color_q;
    out_t pending[$];
    int errors;

    function new();
      for (int i = 0; i < 3; i++) begin
        vx[i] = '0;
        vy[i] = '0;
      end
      row_q = '0;
      mid_row = '0;
      left_acc = 0;
      right_acc = 0;
      scan_phase = 0;
      color_q = '0;
      errors = 0;
    endfunction

    function void swap_pair(int i, int j);
      logic [CoordBits-1:0] t;
      t = vx[i];
      vx[i] = vx[j];
      vx[j] = t;
      t = vy[i];
      vy[i] = vy[j];
      vy[j] = t;
    endfunction

    function int trunc_div(int num, int den);
      if (den == 0) return 0;
      return num / den;
    endfunction

    function void note_item(in_t it);
      out_t s;
      int x0, x1, x2, y0, y1, y2, a, b, r, t;
      logic lo_half;
      logic upper;
      logic [CoordBits-1:0] lo, hi;
      if (it.op == OP_LOAD) begin
        vx[0] = it.vx0;
        vy[0] = it.vy0;
        vx[1] = it.vx1;
        vy[1] = it.vy1;
        vx[2] = it.vx2;
        vy[2] = it.vy2;
        color_q = it.fill_color;
        if (vy[0] > vy[1]) swap_pair(0, 1);
        if (vy[1] > vy[2]) swap_pair(1, 2);
        if (vy[0] > vy[1]) swap_pair(0, 1);
        row_q = {1'b0, vy[0]};
        mid_row = vy[1];
        left_acc = 0;
        right_acc = 0;
        scan_phase = (vy[0] == vy[2]) ? 1 : 2;
        return;
      end
      if (scan_phase == 1) begin
        lo = vx[0];
        hi = vx[0];
        for (int i = 1; i < 3; i++) begin
          if (vx[i] < lo) lo = vx[i];
          if (vx[i] > hi) hi = vx[i];
        end
        s.span_row = vy[0];
        s.span_left = lo;
        s.span_right = hi;
        s.span_color = color_q;
        s.span_last = 1'b1;
        pending.push_back(s);
        scan_phase = 0;
        return;
      end
      if (scan_phase != 2) return;
      x0 = int'(vx[0]);
      x1 = int'(vx[1]);
      x2 = int'(vx[2]);
      y0 = int'(vy[0]);
      y1 = int'(mid_row);
      y2 = int'(vy[2]);
      r = int'(row_q);
      upper = (r < y1) || (r == y1 && y1 == y2);
      if (upper) begin
        a = x0 + trunc_div(left_acc, y1 - y0);
      end else begin
        if (r == y1) left_acc = 0;
        a = x1 + trunc_div(left_acc, y2 - y1);
      end
      b = x0 + trunc_div(right_acc, y2 - y0);
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      lo_half = (r >= y2);
      s.span_row = r[CoordBits-1:0];
      s.span_left = a[CoordBits-1:0];
      s.span_right = b[CoordBits-1:0];
      s.span_color = color_q;
      s.span_last = lo_half;
      pending.push_back(s);
      if (lo_half) begin
        scan_phase = 0;
      end else begin
        left_acc += upper ? (x1 - x0) : (x2 - x1);
        right_acc += x2 - x0;
        row_q = row_q + 1'b1;
      end
    endfunction

    function void check_span(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        report_mismatch("span with nothing expected", 64'sd0, 64'sd0);
        return;
      end
      want = pending.pop_front();
      if (got.span_row !== want.span_row)
        report_mismatch("span_row", longint'(got.span_row), longint'(want.span_row));
      if (got.span_left !== want.span_left)
        report_mismatch("span_left", longint'(got.span_left), longint'(want.span_left));
      if (got.span_right !== want.span_right)
        report_mismatch("span_right", longint'(got.span_right),
                        longint'(want.span_right));
      if (got.span_color !== want.span_color)
        report_mismatch("span_color", longint'(got.span_color),
                        longint'(want.span_color));
      if (got.span_last !== want.span_last)
        report_mismatch("span_last", longint'(got.span_last), longint'(want.span_last));
    endfunction

    function void report_mismatch(string what, longint got, longint want);
      errors++;
      if (errors <= 50)
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  in_t in_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  out_t out_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;

  span_scoreboard board = new();
  int idle_cycles = 0;
  bit stim_done = 0;

  always #1 clk_i = ~clk_i;

  triangle_span_rasterizer_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_i(in_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .out_o(out_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i)
  );

  function int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) board.note_item(in_i);
      if (out_valid_o && !out_stall_i) board.check_span(out_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      g = stim_done ? 0 : gap_len();
      if (g > 0) begin
        out_stall_i <= 1'b1;
        repeat (g) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
    end
  end

  task automatic send_item(in_t it);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic send_load(int x0, int y0, int x1, int y1, int x2, int y2, int c);
    in_t it;
    it.op = OP_LOAD;
    it.vx0 = CoordBits'(x0);
    it.vy0 = CoordBits'(y0);
    it.vx1 = CoordBits'(x1);
    it.vy1 = CoordBits'(y1);
    it.vx2 = CoordBits'(x2);
    it.vy2 = CoordBits'(y2);
    it.fill_color = ColorBits'(c);
    send_item(it);
  endtask

  task automatic send_advance();
    in_t it;
    logic [95:0] r;
    r = {$urandom, $urandom, $urandom};
    it = r[$bits(in_t)-1:0];
    it.op = OP_ADVANCE;
    send_item(it);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (board.pending.size() != 0) @(negedge clk_i);
  endtask

  function int rand_coord();
    int p;
    p = $urandom_range(0, 9);
    if (p == 0) return 0;
    if (p == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  initial begin
    int sent;
    int h;
    int ys;
    int n;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_advance();
    send_load(0, 0, 255, 3, 128, 5, 16'hffff);
    repeat (7) send_advance();
    send_load(255, 7, 0, 7, 10, 7, 16'h0000);
    send_advance();
    send_advance();
    send_load(10, 4, 50, 4, 30, 8, 16'h1234);
    repeat (5) send_advance();
    send_load(30, 2, 0, 6, 255, 6, 16'h8001);
    repeat (3) send_advance();
    send_load(0, 255, 255, 0, 255, 255, 16'h5a5a);
    drain();
    sent = 25;
    while (sent < 1550) begin
      if ($urandom_range(0, 9) == 0) begin
        send_load(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), $urandom_range(0, 65535));
        n = $urandom_range(0, 4);
      end else begin
        ys = $urandom_range(0, 255);
        h = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 12);
        send_load(rand_coord(), ys, rand_coord(), (ys + $urandom_range(0, h)) % 256,
                  rand_coord(), (ys + $urandom_range(0, h)) % 256,
                  $urandom_range(0, 65535));
        n = (h > 20) ? $urandom_range(2, 40) : h + 1 + $urandom_range(0, 2);
      end
      sent++;
      repeat (n) begin
        send_advance();
        sent++;
      end
      if ($urandom_range(0, 30) == 0) drain();
    end
    drain();
    stim_done = 1;
    repeat (200) @(negedge clk_i);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
